/* hw/rtl/gdfw_pkg.sv */
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared types and constants for the depth-first graph walker: channel
// items, command and status codes, controller states and the control and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gdfw_pkg;

  localparam int VERTEX_W   = 5;
  localparam int VERTEX_SPAN = 32;
  localparam int VCOUNT_W   = 6;
  localparam int STATUS_W   = 2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_WALK = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                command;
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dest;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRC_RD,
    ST_SRC_WR,
    ST_DST_RD,
    ST_DST_WR,
    ST_ACK,
    ST_WALK_INIT,
    ST_PUSH,
    ST_TOP,
    ST_CUR,
    ST_NODE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    HSEL_SRC,
    HSEL_DST,
    HSEL_NODE
  } head_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      decode;
    logic      head_rd;
    head_sel_t head_sel;
    logic      link_src;
    logic      link_dst;
    logic      walk_init;
    logic      push;
    logic      pop;
    logic      stack_rd;
    logic      node_rd;
    logic      node_adv;
    logic      visit;
    logic      emit_ack;
    logic      emit_pend;
    logic      emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic item_walk;
    logic out_free;
    logic depth_zero;
    logic cursor_null;
    logic node_new;
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/graph_depth_first_walk.sv */
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// Depth-first walk over an undirected graph kept as adjacency lists.
//
// Command channel (cmd_valid / cmd_stall / cmd_item): an edge command links
// both endpoints at the head of each other's neighbor list and returns one
// result item (vertex 0, last set, status ok, out of range or pool full). A
// walk command clears the visited map and returns the reachable vertices in
// depth-first preorder, newest neighbor first, last set on the final item;
// a start out of range returns one error item. Result channel (res_valid /
// res_stall / res_item) is fed from one output register; a stalled result
// holds the walk at its next emitted vertex. cfg_write loads vertex_count.
// One item is in flight at a time. Edge loads and walks are paced by the
// sequential accesses to the registered-read list, pool and cursor stack
// memories, per list node scanned and per vertex visited.
// Reset empties all lists (head valid bits), the pool count, the visited map
// and stack, and sets vertex_count to 32; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_depth_first_walk #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command items
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire gdfw_pkg::in_item_t            cmd_item,
  // result items
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output gdfw_pkg::out_item_t                res_item,
  // vertex_count register
  input  wire logic                          cfg_write,
  input  wire logic [gdfw_pkg::VCOUNT_W-1:0] cfg_data
);

  gdfw_pkg::ctl_cmd_t   ctl;
  gdfw_pkg::dp_status_t sts;

  // Sequencer: accepts one item in idle, then steps through the link or
  // walk sequence, waiting on the result register where it must emit.
  gdfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Datapath: memories, visited map, stack pointer, checks and result
  // register. The preorder vertex is held pending one step so the final
  // one can carry the last flag.
  gdfw_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd_item  (cmd_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

/* hw/rtl/gdfw_ram.sv */
// ----------------------------------------------------------------------------
// gdfw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gdfw_ctrl.sv */
// ----------------------------------------------------------------------------
// gdfw_ctrl
// Sequencer for edge loads and depth-first walks; drives datapath commands
// from datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire gdfw_pkg::dp_status_t  sts,
  output gdfw_pkg::ctl_cmd_t         ctl
);

  gdfw_pkg::state_t state;
  gdfw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdfw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != gdfw_pkg::ST_IDLE);

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.head_sel = gdfw_pkg::HSEL_SRC;
    unique case (state)
      gdfw_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = gdfw_pkg::ST_DECODE;
        end
      end
      gdfw_pkg::ST_DECODE: begin
        ctl.decode = 1'b1;
        if (!sts.item_ok) begin
          state_next = gdfw_pkg::ST_ACK;
        end else if (sts.item_walk) begin
          state_next = gdfw_pkg::ST_WALK_INIT;
        end else begin
          state_next = gdfw_pkg::ST_SRC_RD;
        end
      end
      gdfw_pkg::ST_SRC_RD: begin
        ctl.head_rd  = 1'b1;
        ctl.head_sel = gdfw_pkg::HSEL_SRC;
        state_next   = gdfw_pkg::ST_SRC_WR;
      end
      gdfw_pkg::ST_SRC_WR: begin
        ctl.link_src = 1'b1;
        state_next   = gdfw_pkg::ST_DST_RD;
      end
      gdfw_pkg::ST_DST_RD: begin
        ctl.head_rd  = 1'b1;
        ctl.head_sel = gdfw_pkg::HSEL_DST;
        state_next   = gdfw_pkg::ST_DST_WR;
      end
      gdfw_pkg::ST_DST_WR: begin
        ctl.link_dst = 1'b1;
        state_next   = gdfw_pkg::ST_ACK;
      end
      gdfw_pkg::ST_ACK: begin
        if (sts.out_free) begin
          ctl.emit_ack = 1'b1;
          state_next   = gdfw_pkg::ST_IDLE;
        end
      end
      gdfw_pkg::ST_WALK_INIT: begin
        ctl.walk_init = 1'b1;
        ctl.head_rd   = 1'b1;
        ctl.head_sel  = gdfw_pkg::HSEL_SRC;
        state_next    = gdfw_pkg::ST_PUSH;
      end
      gdfw_pkg::ST_PUSH: begin
        ctl.push   = 1'b1;
        state_next = gdfw_pkg::ST_TOP;
      end
      gdfw_pkg::ST_TOP: begin
        if (sts.depth_zero) begin
          state_next = gdfw_pkg::ST_FINISH;
        end else begin
          ctl.stack_rd = 1'b1;
          state_next   = gdfw_pkg::ST_CUR;
        end
      end
      gdfw_pkg::ST_CUR: begin
        if (sts.cursor_null) begin
          ctl.pop    = 1'b1;
          state_next = gdfw_pkg::ST_TOP;
        end else begin
          ctl.node_rd = 1'b1;
          state_next  = gdfw_pkg::ST_NODE;
        end
      end
      gdfw_pkg::ST_NODE: begin
        // advance the cursor; descend into an unvisited neighbor
        ctl.node_adv = 1'b1;
        if (!sts.node_new) begin
          state_next = gdfw_pkg::ST_TOP;
        end else if (sts.out_free) begin
          ctl.visit     = 1'b1;
          ctl.emit_pend = 1'b1;
          ctl.head_rd   = 1'b1;
          ctl.head_sel  = gdfw_pkg::HSEL_NODE;
          state_next    = gdfw_pkg::ST_PUSH;
        end
      end
      gdfw_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          ctl.emit_pend = 1'b1;
          ctl.emit_last = 1'b1;
          state_next    = gdfw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gdfw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/gdfw_dpath.sv */
// ----------------------------------------------------------------------------
// gdfw_dpath
// Datapath: list heads, edge pool and cursor stack memories, visited map,
// range and pool checks, pending vertex and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfw_dpath #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire gdfw_pkg::ctl_cmd_t                  ctl,
  output gdfw_pkg::dp_status_t                     sts,
  input  wire gdfw_pkg::in_item_t                  cmd_item,
  input  wire logic                                cfg_write,
  input  wire logic [gdfw_pkg::VCOUNT_W-1:0]       cfg_data,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output gdfw_pkg::out_item_t                      res_item
);

  localparam int VTX_SLOTS  = (MAX_VERTICES < gdfw_pkg::VERTEX_SPAN) ?
                              MAX_VERTICES : gdfw_pkg::VERTEX_SPAN;
  localparam int VIDX_W     = $clog2(VTX_SLOTS);
  localparam int DEPTH_W    = $clog2(VTX_SLOTS + 1);
  localparam int POOL_NODES = 2 * MAX_EDGES;
  localparam int NIDX_W     = $clog2(POOL_NODES);
  localparam int LINK_W     = $clog2(POOL_NODES + 1);
  localparam int NODE_W     = gdfw_pkg::VERTEX_W + LINK_W;
  localparam int FULL_AT    = POOL_NODES - 2;
  localparam int VW         = gdfw_pkg::VERTEX_W;
  localparam int CW         = gdfw_pkg::VCOUNT_W;

  localparam logic [CW-1:0]      SLOT_LIM  = VTX_SLOTS[CW-1:0];
  localparam logic [DEPTH_W-1:0] DEPTH_LIM = VTX_SLOTS[DEPTH_W-1:0];
  localparam logic [LINK_W-1:0]  FULL_MARK = FULL_AT[LINK_W-1:0];

  gdfw_pkg::in_item_t            item;
  logic [CW-1:0]                 vertex_count;
  logic [LINK_W-1:0]             pool_used;
  logic [VTX_SLOTS-1:0]          head_vld;
  logic                          head_vld_q;
  logic [VTX_SLOTS-1:0]          visited;
  logic [DEPTH_W-1:0]            depth;
  logic [VW-1:0]                 pend_vertex;
  logic [gdfw_pkg::STATUS_W-1:0] ack_status;

  logic                          src_ok;
  logic                          dst_ok;
  logic                          pool_full;
  logic [VIDX_W-1:0]             head_raddr;
  logic [VIDX_W-1:0]             head_waddr;
  logic                          head_we;
  logic [LINK_W-1:0]             head_rdata;
  logic [LINK_W-1:0]             head_eff;
  logic [LINK_W-1:0]             new_link;
  logic [NODE_W-1:0]             pool_wdata;
  logic [NODE_W-1:0]             pool_rdata;
  logic [VW-1:0]                 node_w;
  logic [LINK_W-1:0]             node_next;
  logic [LINK_W-1:0]             cursor_idx;
  logic [LINK_W-1:0]             stack_rdata;
  logic [DEPTH_W-1:0]            depth_top;
  logic                          stack_we;
  logic [VIDX_W-1:0]             stack_waddr;
  logic [LINK_W-1:0]             stack_wdata;
  logic                          out_free;

  // ---- checks ----
  assign src_ok    = ({1'b0, item.src} < vertex_count) && ({1'b0, item.src} < SLOT_LIM);
  assign dst_ok    = ({1'b0, item.dest} < vertex_count) && ({1'b0, item.dest} < SLOT_LIM);
  assign pool_full = (pool_used > FULL_MARK);

  assign node_w    = pool_rdata[LINK_W +: VW];
  assign node_next = pool_rdata[LINK_W-1:0];
  assign depth_top = depth - DEPTH_W'(1);
  assign out_free  = !res_valid || !res_stall;

  assign sts.item_ok     = (item.command == gdfw_pkg::CMD_WALK) ? src_ok : (src_ok && dst_ok &&
                           !pool_full);
  assign sts.item_walk   = (item.command == gdfw_pkg::CMD_WALK);
  assign sts.out_free    = out_free;
  assign sts.depth_zero  = (depth == '0);
  assign sts.cursor_null = (stack_rdata == '0);
  assign sts.node_new    = ({1'b0, node_w} < SLOT_LIM) && !visited[node_w[VIDX_W-1:0]] &&
                           (depth < DEPTH_LIM);

  // ---- item and configuration ----
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= cmd_item;
    end
    if (ctl.decode) begin
      if (!src_ok || (item.command == gdfw_pkg::CMD_EDGE && !dst_ok)) begin
        ack_status <= gdfw_pkg::STATUS_RANGE;
      end else if (item.command == gdfw_pkg::CMD_EDGE && pool_full) begin
        ack_status <= gdfw_pkg::STATUS_FULL;
      end else begin
        ack_status <= gdfw_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gdfw_pkg::VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // ---- list heads ----
  always_comb begin
    unique case (ctl.head_sel)
      gdfw_pkg::HSEL_SRC:  head_raddr = item.src[VIDX_W-1:0];
      gdfw_pkg::HSEL_DST:  head_raddr = item.dest[VIDX_W-1:0];
      gdfw_pkg::HSEL_NODE: head_raddr = node_w[VIDX_W-1:0];
      default:             head_raddr = item.src[VIDX_W-1:0];
    endcase
  end

  assign head_we    = ctl.link_src || ctl.link_dst;
  assign head_waddr = ctl.link_src ? item.src[VIDX_W-1:0] : item.dest[VIDX_W-1:0];
  assign new_link   = pool_used + LINK_W'(1);
  assign head_eff   = head_vld_q ? head_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
    end else if (head_we) begin
      head_vld[head_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.head_rd) begin
      head_vld_q <= head_vld[head_raddr];
    end
  end

  gdfw_ram #(
    .WIDTH (LINK_W),
    .DEPTH (VTX_SLOTS)
  ) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (new_link),
    .re    (ctl.head_rd),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  // ---- edge pool ----
  assign pool_wdata = {(ctl.link_src ? item.dest : item.src), head_eff};
  assign cursor_idx = stack_rdata - LINK_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_used <= '0;
    end else if (head_we) begin
      pool_used <= new_link;
    end
  end

  gdfw_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_NODES)
  ) u_pool (
    .clk   (clk),
    .we    (head_we),
    .waddr (pool_used[NIDX_W-1:0]),
    .wdata (pool_wdata),
    .re    (ctl.node_rd),
    .raddr (cursor_idx[NIDX_W-1:0]),
    .rdata (pool_rdata)
  );

  // ---- cursor stack ----
  assign stack_we    = ctl.push || ctl.node_adv;
  assign stack_waddr = ctl.push ? depth[VIDX_W-1:0] : depth_top[VIDX_W-1:0];
  assign stack_wdata = ctl.push ? head_eff : node_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.walk_init) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + DEPTH_W'(1);
    end else if (ctl.pop) begin
      depth <= depth_top;
    end
  end

  gdfw_ram #(
    .WIDTH (LINK_W),
    .DEPTH (VTX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (ctl.stack_rd),
    .raddr (depth_top[VIDX_W-1:0]),
    .rdata (stack_rdata)
  );

  // ---- visited map and pending vertex ----
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (ctl.walk_init) begin
      // clear the map and mark the start vertex only
      visited <= VTX_SLOTS'(1) << item.src[VIDX_W-1:0];
    end else if (ctl.visit) begin
      visited[node_w[VIDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_init) begin
      pend_vertex <= item.src;
    end else if (ctl.visit) begin
      pend_vertex <= node_w;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit_ack || ctl.emit_pend) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_ack) begin
      res_item.vertex <= '0;
      res_item.last   <= 1'b1;
      res_item.status <= ack_status;
    end else if (ctl.emit_pend) begin
      res_item.vertex <= pend_vertex;
      res_item.last   <= ctl.emit_last;
      res_item.status <= gdfw_pkg::STATUS_OK;
    end
  end

endmodule

`default_nettype wire
